// ===== rtl/core/segment13_compander_macros.svh =====
// ----------------------------------------------------------------------------
// segment13_compander_macros.svh
// Assertion shorthands for the 13-segment compander.
// ----------------------------------------------------------------------------
`ifndef SEGMENT13_COMPANDER_MACROS_SVH
`define SEGMENT13_COMPANDER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define S13C_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in cycles, disabled in reset.
`define S13C_ASSERT_DLY(lbl, ck, rs, ante, n, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/s13c_pkg.sv =====
// ----------------------------------------------------------------------------
// s13c_pkg
// Shared types and constants for the 13-segment compander.
// ----------------------------------------------------------------------------
package s13c_pkg;

  typedef enum logic {
    ACT_COMPRESS = 1'b0,
    ACT_EXPAND   = 1'b1
  } action_t;

  typedef struct packed {
    action_t            action;
    logic signed [15:0] sample_in;
    logic        [7:0]  code_in;
  } in_t;

  typedef struct packed {
    logic        [7:0]  code_out;
    logic signed [15:0] sample_out;
  } out_t;

  // Sideband that follows an item down the pipe
  typedef struct packed {
    action_t act;
    logic    neg;
  } side_t;

  // Segment edges on 8*code for expansion (first three inclusive)
  localparam logic [9:0] EXP_EDGE0 = 10'd254;
  localparam logic [9:0] EXP_EDGE1 = 10'd381;
  localparam logic [9:0] EXP_EDGE2 = 10'd508;
  localparam logic [9:0] EXP_EDGE3 = 10'd635;
  localparam logic [9:0] EXP_EDGE4 = 10'd762;
  localparam logic [9:0] EXP_EDGE5 = 10'd889;

  localparam logic [6:0] CODE_MAG_MAX = 7'd127;
  localparam logic [9:0] CODE_SCALE   = 10'd127;

endpackage

// ===== rtl/core/s13c_front.sv =====
// ----------------------------------------------------------------------------
// s13c_front
// Segment pick and dividend forming for both actions.
// ----------------------------------------------------------------------------
module s13c_front import s13c_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  in_t                      item,
  output logic [SAMPLE_BITS+6:0]   num,
  output side_t                    side
);

  localparam int N1 = SAMPLE_BITS - 1;
  localparam int W  = N1 + 8;
  localparam logic [N1-1:0] FULL = {N1{1'b1}};

  // compress path
  logic [16:0]   s_ext;
  logic [16:0]   mag;
  logic [N1-1:0] x;
  logic [N1+5:0] xw;
  logic [N1+5:0] fw;
  logic [2:0]    kc;
  logic [2:0]    shc;
  logic [W-1:0]  y;
  logic [W+2:0]  y127;
  logic [W-1:0]  num_c;

  // expand path
  logic [9:0]     c8;
  logic [2:0]     ke;
  logic [2:0]     she;
  logic [9:0]     base;
  logic [9:0]     diff;
  logic [N1+9:0]  pd;
  logic [W-1:0]   num_e;

  always_comb begin
    s_ext = {item.sample_in[15], item.sample_in};
    mag   = item.sample_in[15] ? (17'd0 - s_ext) : s_ext;
    x     = (mag > 17'(FULL)) ? FULL : mag[N1-1:0];
    xw    = (N1+6)'(x);
    fw    = (N1+6)'(FULL);
    priority if ((xw << 6) <= fw) begin
      kc = 3'd0;
    end else if ((xw << 5) <= fw) begin
      kc = 3'd1;
    end else if ((xw << 4) <= fw) begin
      kc = 3'd2;
    end else if ((xw << 3) < fw) begin
      kc = 3'd3;
    end else if ((xw << 2) < fw) begin
      kc = 3'd4;
    end else if ((xw << 1) < fw) begin
      kc = 3'd5;
    end else begin
      kc = 3'd6;
    end
    shc   = 3'd7 - kc;
    // A*x + B*F with A = 2^(7-k), B = k
    y     = (W'(x) << shc) + (W'(kc) * W'(FULL));
    y127  = ((W+3)'(y) << 7) - (W+3)'(y);
    num_c = y127[W+2:3];
  end

  always_comb begin
    c8 = {item.code_in[6:0], 3'b000};
    priority if (c8 <= EXP_EDGE0) begin
      ke = 3'd0;
    end else if (c8 <= EXP_EDGE1) begin
      ke = 3'd1;
    end else if (c8 <= EXP_EDGE2) begin
      ke = 3'd2;
    end else if (c8 < EXP_EDGE3) begin
      ke = 3'd3;
    end else if (c8 < EXP_EDGE4) begin
      ke = 3'd4;
    end else if (c8 < EXP_EDGE5) begin
      ke = 3'd5;
    end else begin
      ke = 3'd6;
    end
    she   = 3'd7 - ke;
    base  = 10'(ke) * CODE_SCALE;
    diff  = (c8 > base) ? (c8 - base) : 10'd0;
    // diff * F, then the power-of-two part of 127*A
    pd    = ((N1+10)'(diff) << N1) - (N1+10)'(diff);
    num_e = W'(pd >> she);
  end

  always_comb begin
    if (item.action == ACT_EXPAND) begin
      num      = num_e;
      side.neg = item.code_in[7];
    end else begin
      num      = num_c;
      side.neg = item.sample_in[15];
    end
    side.act = item.action;
  end

endmodule

// ===== rtl/core/s13c_mdiv.sv =====
// ----------------------------------------------------------------------------
// s13c_mdiv
// Two-stage floor divide by the constant 2^M - 1: reciprocal multiply, then
// one remainder check.
// ----------------------------------------------------------------------------
module s13c_mdiv #(
  parameter int W = 23,
  parameter int M = 7
) (
  input  logic             clk,
  input  logic [W-1:0]     num,
  output logic [W-M:0]     quo
);

  localparam int RW = W - M + 1;
  localparam logic [RW-1:0] RECIP = RW'((2**W) / (2**M - 1));
  localparam logic [W:0]    DIV   = (W+1)'(2**M - 1);

  logic [W+RW-1:0] prod;
  logic [W-1:0]    num_d;
  logic [RW-1:0]   q_est;
  logic [W:0]      q_mul;
  logic [W:0]      rem;
  logic [RW-1:0]   quo_next;

  always_ff @(posedge clk) begin
    prod  <= (W+RW)'(num) * (W+RW)'(RECIP);
    num_d <= num;
  end

  // estimate is low by at most one
  always_comb begin
    q_est    = prod[W+RW-1:W];
    q_mul    = ((W+1)'(q_est) << M) - (W+1)'(q_est);
    rem      = {1'b0, num_d} - q_mul;
    quo_next = (rem >= DIV) ? (q_est + 1'b1) : q_est;
  end

  always_ff @(posedge clk) begin
    quo <= quo_next;
  end

endmodule

// ===== rtl/core/segment13_compander.sv =====
// ----------------------------------------------------------------------------
// segment13_compander
// 13-segment compander: compresses a PCM sample to an 8-bit sign-magnitude
// code, or expands a code back to a sample, one item per clock.
// ----------------------------------------------------------------------------
//
//  channel | ports              | transfer
//  --------+--------------------+-------------------------------------
//  item    | start, busy, item  | start high while busy low
//  result  | done, result       | done high, one cycle, no hold-off
//
// An item may be taken every cycle; busy never rises.
// done rises at the same edge that loads the result register, and the
// receiver takes the result while done is high. The five registers are the input
// register, the dividend register, the two stages of each constant divider,
// then the result register.
// Reset clears the valid pipe only; items in flight are dropped.
// The receiver cannot stall, so nothing in the pipe ever waits.
// ----------------------------------------------------------------------------
`include "segment13_compander_macros.svh"

module segment13_compander import s13c_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic done,
  output out_t result
);

  localparam int N1   = SAMPLE_BITS - 1;
  localparam int W    = N1 + 8;          // dividend width for both actions
  localparam int RW_C = W - N1 + 1;      // compress quotient width
  localparam int RW_E = W - 7 + 1;       // expand quotient width
  localparam logic [N1-1:0] FULL = {N1{1'b1}};
  localparam int SMAX = 2**N1 - 1;

  // pipe valid bits: input reg, dividend reg, divider stage 1 and 2
  logic [3:0]     vld;
  side_t          side0, side1, side2, side3;
  in_t            item_q;

  logic [W-1:0]   num_f;
  side_t          side_f;
  logic [W-1:0]   num_q;

  logic [RW_C-1:0] q_c;
  logic [RW_E-1:0] q_e;

  logic [6:0]     cm;
  logic [N1-1:0]  mag_e;
  logic [15:0]    mag16;
  out_t           result_next;

  // The pipe always advances, so the input side is never held off.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[2:0], start && !busy};
      done <= vld[3];
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= item;
    end
  end

  s13c_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .item (item_q),
    .num  (num_f),
    .side (side_f)
  );

  always_ff @(posedge clk) begin
    num_q <= num_f;
    side1 <= side_f;
    side2 <= side1;
    side3 <= side2;
  end

  assign side0 = side_f;

  // floor(v / F) for compression, floor(t / 127) for expansion
  s13c_mdiv #(
    .W(W),
    .M(N1)
  ) u_div_cmp (
    .clk (clk),
    .num (num_q),
    .quo (q_c)
  );

  s13c_mdiv #(
    .W(W),
    .M(7)
  ) u_div_exp (
    .clk (clk),
    .num (num_q),
    .quo (q_e)
  );

  // Clamp, apply sign, zero the field the action does not use.
  always_comb begin
    cm    = (q_c > RW_C'(CODE_MAG_MAX)) ? CODE_MAG_MAX : q_c[6:0];
    mag_e = (q_e > RW_E'(FULL)) ? FULL : q_e[N1-1:0];
    mag16 = 16'(mag_e);
    if (side3.act == ACT_EXPAND) begin
      result_next.code_out   = 8'd0;
      result_next.sample_out = side3.neg ? (16'd0 - mag16) : mag16;
    end else begin
      result_next.code_out   = {side3.neg, cm};
      result_next.sample_out = 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // side0 is the front-end view of the sideband; expansion codes must carry
  // their own sign into the pipe.
  `S13C_ASSERT_IMP(a_side_sign, clk, rst,
                   vld[0] && item_q.action == ACT_EXPAND,
                   side0.neg == item_q.code_in[7],
                   "expand sign lost at front end")

  `S13C_ASSERT_DLY(a_latency, clk, rst, start && !busy, 5, done,
                   "accepted item produced no result")

  `S13C_ASSERT_IMP(a_one_field, clk, rst, done && result.code_out != 8'd0,
                   result.sample_out == 16'sd0, "both result fields nonzero")

  `S13C_ASSERT_IMP(a_range, clk, rst, done,
                   (int'(result.sample_out) <= SMAX) && (int'(result.sample_out) >= -SMAX),
                   "expanded sample beyond full scale")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 13-segment compander. Directed edge items and
// random compress/expand items are queued, driven with random idle bursts and
// checked result by result against a bit-exact integer model of the curve.
// ----------------------------------------------------------------------------
module tb_top;
  import s13c_pkg::*;

  localparam int          SAMPLE_BITS = 16;
  localparam longint unsigned FULL    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam int          N_RANDOM    = 500;
  localparam int          N_CALM      = 100;  // tail of the run that draws no new idle bursts
  localparam int          DRAIN_WAIT  = 20;
  localparam int          STALL_LIMIT = 200;  // cycles with no transfer at all

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t  item  = '0;
  logic done;
  out_t result;

  segment13_compander #(.SAMPLE_BITS(SAMPLE_BITS)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  // Items waiting to be driven, and the results they must produce, in order.
  in_t  stimulus_items[$];
  out_t expected_results[$];

  int   mismatch_count = 0;
  int   compress_sent  = 0;
  int   expand_sent    = 0;
  int   results_seen   = 0;
  int   idle_left      = 0;
  int   stall_cycles   = 0;
  bit   random_phase   = 1'b0;
  out_t want;

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Integer model of the companding curve.
  // Segment k has slope 128>>k and offset k, both in eighths. Compression:
  //   code = floor(127*(A*x + B*F) / (8*F)), x = |s| clamped to F.
  // Expansion: mag = floor((8*c - 127*B) * F / (127*A)), clamped to F.
  // Every negative sample sets bit 7, even when its magnitude code is zero;
  // the field that the action does not use reads as zero.
  // --------------------------------------------------------------------------
  function automatic out_t compand_predict(in_t it);
    out_t            r;
    logic [63:0]     mag;
    logic [63:0]     cm;
    logic [63:0]     c;
    logic [63:0]     diff;
    logic [63:0]     slope8;
    int unsigned     seg;
    logic            neg;
    r = '0;
    if (it.action == ACT_COMPRESS) begin
      neg = it.sample_in[15];
      mag = neg ? (64'h10000 - {48'd0, it.sample_in}) : {48'd0, it.sample_in};
      if (mag > FULL) mag = FULL;  // -32768 folds onto full scale
      // the bounds of segments 0 to 2 are inclusive, the rest exclusive
      if      (64 * mag <= FULL) seg = 0;
      else if (32 * mag <= FULL) seg = 1;
      else if (16 * mag <= FULL) seg = 2;
      else if (8 * mag < FULL)   seg = 3;
      else if (4 * mag < FULL)   seg = 4;
      else if (2 * mag < FULL)   seg = 5;
      else                       seg = 6;
      slope8 = 64'd128 >> seg;
      cm = (127 * (slope8 * mag + seg * FULL)) / (8 * FULL);
      if (cm > 127) cm = 127;
      r.code_out = {neg, cm[6:0]};
    end else begin
      neg = it.code_in[7];
      c   = {57'd0, it.code_in[6:0]};
      if      (8 * c <= EXP_EDGE0) seg = 0;
      else if (8 * c <= EXP_EDGE1) seg = 1;
      else if (8 * c <= EXP_EDGE2) seg = 2;
      else if (8 * c < EXP_EDGE3)  seg = 3;
      else if (8 * c < EXP_EDGE4)  seg = 4;
      else if (8 * c < EXP_EDGE5)  seg = 5;
      else                         seg = 6;
      slope8 = 64'd128 >> seg;
      diff   = (8 * c > 127 * seg) ? (8 * c - 127 * seg) : 64'd0;
      mag    = (diff * FULL) / (127 * slope8);
      if (mag > FULL) mag = FULL;
      // code 128 (negative zero) comes back as plain zero
      r.sample_out = neg ? 16'(64'h10000 - mag) : mag[15:0];
    end
    return r;
  endfunction

  function automatic in_t make_item(action_t a, logic signed [15:0] s, logic [7:0] c);
    in_t it;
    it.action    = a;
    it.sample_in = s;
    it.code_in   = c;
    return it;
  endfunction

  // Random samples lean toward small magnitudes, segment edges and full scale,
  // since a flat spread would land almost entirely in the top segments.
  function automatic logic signed [15:0] random_sample();
    logic signed [15:0] s;
    int                 edge_sel;
    s = 16'($urandom());
    case ($urandom_range(0, 3))
      0: ;
      1: s = s >>> $urandom_range(0, 14);
      2: begin
        edge_sel = $urandom_range(9, 14);
        s = 16'((1 << edge_sel) + $urandom_range(0, 4) - 2);
        if ($urandom_range(0, 1)) s = -s;
      end
      default: begin
        s = 16'(32767 - $urandom_range(0, 3));
        if ($urandom_range(0, 1)) s = ($urandom_range(0, 3) == 0) ? 16'sh8000 : -s;
      end
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("ERROR @%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, want_v, got_v);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: a transfer happens at an edge with start high and busy low. The
  // expectation is queued at that edge, then the next item is put up unless a
  // random idle burst is drawn; the calm tail of the run draws no new ones.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      item      <= '0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(compand_predict(item));
        void'(stimulus_items.pop_front());
        if (item.action == ACT_COMPRESS) compress_sent++;
        else                             expand_sent++;
      end
      if (start && busy) begin
        start <= 1'b1;  // hold the offered item until it is taken
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start     <= 1'b0;
      end else if (stimulus_items.size() > 0 &&
                   !(random_phase && stimulus_items.size() <= N_CALM) &&
                   $urandom_range(0, 5) == 0) begin
        idle_left <= $urandom_range(0, 3);
        start     <= 1'b0;
      end else if (stimulus_items.size() > 0) begin
        start <= 1'b1;
        item  <= stimulus_items[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: done marks a one-cycle result that cannot be held off; compare it
  // field by field with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 32'(result));
      end else begin
        want = expected_results.pop_front();
        if (result.code_out !== want.code_out)
          report_mismatch("code_out", 32'(want.code_out), 32'(result.code_out));
        if (result.sample_out !== want.sample_out)
          report_mismatch("sample_out", 32'(want.sample_out), 32'(result.sample_out));
      end
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // directed part: segment edges from both sides, overrange, signed zero
    stimulus_items.push_back(make_item(ACT_COMPRESS, 16'sd0, 8'hA5));
    stimulus_items.push_back(make_item(ACT_COMPRESS, 16'sd1, 8'h5A));
    stimulus_items.push_back(make_item(ACT_COMPRESS, -16'sd1, 8'hFF));
    stimulus_items.push_back(make_item(ACT_COMPRESS, 16'sd32767, 8'h00));
    stimulus_items.push_back(make_item(ACT_COMPRESS, -16'sd32767, 8'h0F));
    stimulus_items.push_back(make_item(ACT_COMPRESS, 16'sh8000, 8'hF0));
    stimulus_items.push_back(make_item(ACT_COMPRESS, 16'sd511, 8'h33));
    stimulus_items.push_back(make_item(ACT_COMPRESS, 16'sd512, 8'h33));
    stimulus_items.push_back(make_item(ACT_COMPRESS, -16'sd4096, 8'hCC));
    stimulus_items.push_back(make_item(ACT_COMPRESS, 16'sd16384, 8'h11));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'sh7FFF, 8'd0));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'sh8000, 8'd127));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'sh5555, 8'd128));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'shAAAA, 8'd255));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'sh0000, 8'd31));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'shFFFF, 8'd32));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'sh1234, 8'd63));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'shEDCB, 8'd64));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'sh0F0F, 8'd79));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'shF0F0, 8'd208));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'sh00FF, 8'd111));
    stimulus_items.push_back(make_item(ACT_EXPAND, 16'shFF00, 8'd240));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // hold off the random part until every directed result is back
    while (stimulus_items.size() != 0 || expected_results.size() != 0) @(negedge clk);

    for (int i = 0; i < N_RANDOM; i++)
      stimulus_items.push_back(make_item(action_t'($urandom_range(0, 1)), random_sample(),
                                         8'($urandom())));
    random_phase = 1'b1;

    while (stimulus_items.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());

    $display("Covered %0d compress and %0d expand transfers, %0d results checked,",
             compress_sent, expand_sent, results_seen);
    $display("including segment edges, overrange and negative zero; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/s13c_pkg.sv
rtl/core/s13c_front.sv
rtl/core/s13c_mdiv.sv
rtl/core/segment13_compander.sv
test/tb_top.sv
